[rtl/psd_pkg.sv]
// shared types and constants for the point to segment distance block
// no dependencies
package psd_pkg;

    localparam int COORD_BITS = 32;
    localparam int DIFF_BITS  = COORD_BITS + 1;

    typedef enum logic [1:0] {
        ST_ON    = 2'd0,
        ST_OFF   = 2'd1,
        ST_DEGEN = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] start_z;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic signed [COORD_BITS-1:0] end_z;
    } t_in_word;

    typedef struct packed {
        t_status                      status;
        logic        [COORD_BITS:0]   distance;
        logic signed [COORD_BITS-1:0] foot_x;
        logic signed [COORD_BITS-1:0] foot_y;
        logic signed [COORD_BITS-1:0] foot_z;
    } t_out_word;

    // side data carried along the divider
    typedef struct packed {
        t_status                       status;
        logic                          eq;
        logic [2:0][COORD_BITS-1:0]    p;
        logic [2:0][COORD_BITS-1:0]    s;
        logic [2:0][DIFF_BITS-1:0]     d;
    } t_geo;

    // side data carried along the square root
    typedef struct packed {
        t_status                       status;
        logic [2:0][COORD_BITS-1:0]    foot;
    } t_res;

endpackage

[rtl/point_segment_distance.sv]
// top level of the point to segment distance pipeline
// depends on psd_pkg
//
// usage:
//   input channel (i_in_valid / o_in_ready / i_in_data) takes one word per cycle,
//   each word holds a point and the two end points of a segment
//   output channel (o_out_valid / i_out_ready / o_out_data) returns one word for
//   every input word, in order: status, distance and foot of the perpendicular
//   i_cfg_we / i_cfg_wdata write plane_mode (0 = 3d, 1 = 2d with z held at zero);
//   write it only while the pipeline is empty
// latency: 4 + 40 + 6 + 34 + 1 = 85 cycles from accept to valid output
//   (40 one-bit divider stages for u, 34 one-bit square root stages)
// throughput: one word per cycle, set by the fully pipelined divider and root
// reset: synchronous, clears all stage valid bits and plane_mode
// stall: when the output word is not taken the whole pipeline holds and
//   o_in_ready drops; nothing is lost or repeated, bubbles pass through
module point_segment_distance (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  psd_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output psd_pkg::t_out_word o_out_data
);

    localparam int CW   = psd_pkg::COORD_BITS;
    localparam int DW   = psd_pkg::DIFF_BITS;   // coordinate differences
    localparam int PW   = 2 * DW;               // products
    localparam int SW   = PW + 2;               // sums of three products
    localparam int UF   = CW + 8;               // fraction bits of u
    localparam int UW   = UF + 1;               // u including the integer bit
    localparam int ULO  = UW / 2;
    localparam int UHI  = UW - ULO;
    localparam int TW   = CW + UW + 1;          // foot offset sum
    localparam int RW   = SW / 2;               // root bits
    localparam int QW   = RW + 2;               // root remainder bits
    localparam int NSTG = 4 + UF + 6 + RW + 1;

    // global stage enable: everything moves unless the output word is stuck
    logic            en;
    logic [NSTG-1:0] r_vld;
    logic            r_plane_mode;

    assign en          = !r_vld[NSTG-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_plane_mode <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[NSTG-2:0], i_in_valid};
            end
            if (i_cfg_we) begin
                r_plane_mode <= i_cfg_wdata;
            end
        end
    end

    // ---------------------------------------------------------------- stage a
    // differences d = e - s and v = p - s; 2d mode zeroes every z input
    logic signed [CW-1:0] a_p [3];
    logic signed [CW-1:0] a_s [3];
    logic signed [CW-1:0] a_e [3];
    logic signed [DW-1:0] n_a_d [3];
    logic signed [DW-1:0] n_a_v [3];
    logic signed [DW-1:0] r_a_d [3];
    logic signed [DW-1:0] r_a_v [3];
    logic signed [CW-1:0] r_a_p [3];
    logic signed [CW-1:0] r_a_s [3];

    assign a_p[0] = i_in_data.point_x;
    assign a_p[1] = i_in_data.point_y;
    assign a_p[2] = r_plane_mode ? '0 : i_in_data.point_z;
    assign a_s[0] = i_in_data.start_x;
    assign a_s[1] = i_in_data.start_y;
    assign a_s[2] = r_plane_mode ? '0 : i_in_data.start_z;
    assign a_e[0] = i_in_data.end_x;
    assign a_e[1] = i_in_data.end_y;
    assign a_e[2] = r_plane_mode ? '0 : i_in_data.end_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a_d[i] = {a_e[i][CW-1], a_e[i]} - {a_s[i][CW-1], a_s[i]};
            n_a_v[i] = {a_p[i][CW-1], a_p[i]} - {a_s[i][CW-1], a_s[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_a_d[i] <= n_a_d[i];
                r_a_v[i] <= n_a_v[i];
                r_a_p[i] <= a_p[i];
                r_a_s[i] <= a_s[i];
            end
        end
    end

    // ---------------------------------------------------------------- stage b
    // per-axis products for the dot product and squared length
    logic signed [PW-1:0] r_b_vd [3];
    logic signed [PW-1:0] r_b_dd [3];
    logic signed [DW-1:0] r_b_d  [3];
    logic signed [CW-1:0] r_b_p  [3];
    logic signed [CW-1:0] r_b_s  [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_b_vd[i] <= r_a_v[i] * r_a_d[i];
                r_b_dd[i] <= r_a_d[i] * r_a_d[i];
                r_b_d[i]  <= r_a_d[i];
                r_b_p[i]  <= r_a_p[i];
                r_b_s[i]  <= r_a_s[i];
            end
        end
    end

    // ---------------------------------------------------------------- stage c
    logic signed [SW-1:0] r_c_dot;
    logic        [SW-1:0] r_c_len;
    logic signed [DW-1:0] r_c_d [3];
    logic signed [CW-1:0] r_c_p [3];
    logic signed [CW-1:0] r_c_s [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_dot <= SW'(r_b_vd[0]) + SW'(r_b_vd[1]) + SW'(r_b_vd[2]);
            r_c_len <= SW'(r_b_dd[0]) + SW'(r_b_dd[1]) + SW'(r_b_dd[2]);
            for (int i = 0; i < 3; i++) begin
                r_c_d[i] <= r_b_d[i];
                r_c_p[i] <= r_b_p[i];
                r_c_s[i] <= r_b_s[i];
            end
        end
    end

    // ---------------------------------------------------------------- stage d
    // classify: degenerate, foot outside, or on segment
    psd_pkg::t_geo n_d_geo;
    psd_pkg::t_geo r_d_geo;
    logic [SW-1:0] r_d_rem;
    logic [SW-1:0] r_d_len;

    always_comb begin
        n_d_geo = '0;
        priority if (r_c_len == '0) begin
            n_d_geo.status = psd_pkg::ST_DEGEN;
        end else if (r_c_dot[SW-1]) begin
            n_d_geo.status = psd_pkg::ST_OFF;
        end else if (r_c_dot[SW-1:0] > r_c_len) begin
            n_d_geo.status = psd_pkg::ST_OFF;
        end else begin
            n_d_geo.status = psd_pkg::ST_ON;
        end
        // u = 1 exactly is not reachable by the divider, so it is flagged
        n_d_geo.eq = (r_c_dot[SW-1:0] == r_c_len);
        for (int i = 0; i < 3; i++) begin
            n_d_geo.p[i] = r_c_p[i];
            n_d_geo.s[i] = r_c_s[i];
            n_d_geo.d[i] = r_c_d[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_geo <= n_d_geo;
            r_d_rem <= (n_d_geo.status == psd_pkg::ST_ON) ? r_c_dot[SW-1:0] : '0;
            r_d_len <= r_c_len;
        end
    end

    // ---------------------------------------------------------------- divider
    // restoring division, one quotient bit per stage
    logic [SW-1:0]  q_rem_in [UF];
    logic [SW-1:0]  q_len_in [UF];
    logic [UF-1:0]  q_quo_in [UF];
    psd_pkg::t_geo  q_geo_in [UF];
    logic [SW-1:0]  r_q_rem  [UF];
    logic [SW-1:0]  r_q_len  [UF];
    logic [UF-1:0]  r_q_quo  [UF];
    psd_pkg::t_geo  r_q_geo  [UF];

    for (genvar k = 0; k < UF; k++) begin : g_div
        logic [SW:0] sh;
        logic [SW:0] diff;
        logic        ge;

        if (k == 0) begin : g_first
            assign q_rem_in[k] = r_d_rem;
            assign q_len_in[k] = r_d_len;
            assign q_quo_in[k] = '0;
            assign q_geo_in[k] = r_d_geo;
        end else begin : g_next
            assign q_rem_in[k] = r_q_rem[k-1];
            assign q_len_in[k] = r_q_len[k-1];
            assign q_quo_in[k] = r_q_quo[k-1];
            assign q_geo_in[k] = r_q_geo[k-1];
        end

        assign sh   = {q_rem_in[k], 1'b0};
        assign diff = sh - {1'b0, q_len_in[k]};
        assign ge   = (sh >= {1'b0, q_len_in[k]});

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_q_rem[k] <= ge ? diff[SW-1:0] : sh[SW-1:0];
                r_q_len[k] <= q_len_in[k];
                r_q_quo[k] <= {q_quo_in[k][UF-2:0], ge};
                r_q_geo[k] <= q_geo_in[k];
            end
        end
    end

    // --------------------------------------------------------------- stage m1
    // |d| * u split in two partial products
    psd_pkg::t_geo         m1_geo;
    logic [UW-1:0]         m1_u;
    logic [CW-1:0]         m1_mag [3];
    logic [CW+ULO-1:0]     r_m1_lo [3];
    logic [CW+UHI-1:0]     r_m1_hi [3];
    psd_pkg::t_geo         r_m1_geo;

    assign m1_geo = r_q_geo[UF-1];
    assign m1_u   = m1_geo.eq ? {1'b1, {UF{1'b0}}} : {1'b0, r_q_quo[UF-1]};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m1_mag[i] = m1_geo.d[i][DW-1] ? CW'(-$signed(m1_geo.d[i])) : CW'(m1_geo.d[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_m1_lo[i] <= m1_mag[i] * m1_u[ULO-1:0];
                r_m1_hi[i] <= m1_mag[i] * m1_u[UW-1:ULO];
            end
            r_m1_geo <= m1_geo;
        end
    end

    // --------------------------------------------------------------- stage m2
    // round to nearest on the u fraction
    logic [TW-1:0] m2_t [3];
    logic [CW-1:0] r_m2_m [3];
    psd_pkg::t_geo r_m2_geo;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m2_t[i] = TW'(r_m1_lo[i]) + (TW'(r_m1_hi[i]) << ULO) + (TW'(1) << (UF - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_m2_m[i] <= m2_t[i][UF +: CW];
            end
            r_m2_geo <= r_m1_geo;
        end
    end

    // --------------------------------------------------------------- stage m3
    // foot = s +/- m, always between the end points
    logic [DW-1:0]        m3_f [3];
    logic signed [CW-1:0] r_m3_p [3];
    psd_pkg::t_res        r_m3_res;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_m2_geo.d[i][DW-1]) begin
                m3_f[i] = {r_m2_geo.s[i][CW-1], r_m2_geo.s[i]} - {1'b0, r_m2_m[i]};
            end else begin
                m3_f[i] = {r_m2_geo.s[i][CW-1], r_m2_geo.s[i]} + {1'b0, r_m2_m[i]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m3_res.status <= r_m2_geo.status;
            for (int i = 0; i < 3; i++) begin
                r_m3_res.foot[i] <= m3_f[i][CW-1:0];
                r_m3_p[i]        <= r_m2_geo.p[i];
            end
        end
    end

    // --------------------------------------------------------------- stage m4
    logic signed [DW-1:0] r_m4_e [3];
    psd_pkg::t_res        r_m4_res;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_m4_e[i] <= {r_m3_p[i][CW-1], r_m3_p[i]}
                           - {r_m3_res.foot[i][CW-1], r_m3_res.foot[i]};
            end
            r_m4_res <= r_m3_res;
        end
    end

    // --------------------------------------------------------------- stage m5
    logic [PW-1:0] r_m5_sq [3];
    psd_pkg::t_res r_m5_res;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                // full width square, operands sign extended by the target width
                r_m5_sq[i] <= r_m4_e[i] * r_m4_e[i];
            end
            r_m5_res <= r_m4_res;
        end
    end

    // --------------------------------------------------------------- stage m6
    logic [SW-1:0] r_m6_acc;
    psd_pkg::t_res r_m6_res;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m6_acc <= SW'(r_m5_sq[0]) + SW'(r_m5_sq[1]) + SW'(r_m5_sq[2]);
            r_m6_res <= r_m5_res;
        end
    end

    // ------------------------------------------------------------ square root
    // digit by digit, two radicand bits per stage, remainder kept
    logic [QW-1:0] s_rem_in  [RW];
    logic [RW-1:0] s_root_in [RW];
    logic [SW-1:0] s_bits_in [RW];
    psd_pkg::t_res s_res_in  [RW];
    logic [QW-1:0] r_s_rem   [RW];
    logic [RW-1:0] r_s_root  [RW];
    logic [SW-1:0] r_s_bits  [RW];
    psd_pkg::t_res r_s_res   [RW];

    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        logic [QW+1:0] cur;
        logic [QW+1:0] trial;
        logic [QW+1:0] diff;
        logic          ge;

        if (j == 0) begin : g_first
            assign s_rem_in[j]  = '0;
            assign s_root_in[j] = '0;
            assign s_bits_in[j] = r_m6_acc;
            assign s_res_in[j]  = r_m6_res;
        end else begin : g_next
            assign s_rem_in[j]  = r_s_rem[j-1];
            assign s_root_in[j] = r_s_root[j-1];
            assign s_bits_in[j] = r_s_bits[j-1];
            assign s_res_in[j]  = r_s_res[j-1];
        end

        assign cur   = {s_rem_in[j], s_bits_in[j][SW-1:SW-2]};
        assign trial = {2'b00, s_root_in[j], 2'b01};
        assign ge    = (cur >= trial);
        assign diff  = cur - trial;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s_rem[j]  <= ge ? diff[QW-1:0] : cur[QW-1:0];
                r_s_root[j] <= {s_root_in[j][RW-2:0], ge};
                r_s_bits[j] <= {s_bits_in[j][SW-3:0], 2'b00};
                r_s_res[j]  <= s_res_in[j];
            end
        end
    end

    // ------------------------------------------------------------ output word
    // round the root to nearest, saturate, zero distance and foot unless on segment
    logic [RW:0]        o_dsum;
    logic [DW-1:0]      o_dist;
    psd_pkg::t_res      o_res;
    psd_pkg::t_out_word n_out;
    psd_pkg::t_out_word r_out;

    assign o_res  = r_s_res[RW-1];
    assign o_dsum = {1'b0, r_s_root[RW-1]}
                  + (RW+1)'(r_s_rem[RW-1] > QW'(r_s_root[RW-1]));
    assign o_dist = (o_dsum > (RW+1)'({DW{1'b1}})) ? {DW{1'b1}} : o_dsum[DW-1:0];

    always_comb begin
        n_out        = '0;
        n_out.status = o_res.status;
        if (o_res.status == psd_pkg::ST_ON) begin
            n_out.distance = o_dist;
            n_out.foot_x   = o_res.foot[0];
            n_out.foot_y   = o_res.foot[1];
            n_out.foot_z   = o_res.foot[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

[rtl/psd_check.sv]
// port-level checks for point_segment_distance, bound to the top level
// depends on psd_pkg
module psd_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_we,
    input logic               i_cfg_wdata,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input psd_pkg::t_in_word  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input psd_pkg::t_out_word o_out_data
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output word dropped or changed under stall");

    // an offered input word waits unchanged until it is taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input word dropped or changed while waiting");

    // mode writes only land on an idle output with a known value
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> !o_out_valid && !$isunknown(i_cfg_wdata))
        else $error("mode written while words are in flight");

    // off-segment and degenerate words carry no geometry
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != psd_pkg::ST_ON |->
            o_out_data.distance == '0 && o_out_data.foot_x == '0 &&
            o_out_data.foot_y == '0 && o_out_data.foot_z == '0)
        else $error("nonzero fields on an off-segment word");

endmodule

bind point_segment_distance psd_check u_psd_check (.*);

[tb/tb_point_segment_distance.sv]
// testbench for the point to segment distance pipeline
// depends on psd_pkg and point_segment_distance
module tb_point_segment_distance;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB        = psd_pkg::COORD_BITS;
    localparam int U_FRAC    = CB + 8;
    localparam int LATENCY   = 85;
    localparam int WDOG_MAX  = 20000;

    // scoreboard: predicts one result word per accepted input word
    class foot_scoreboard;
        psd_pkg::t_out_word expected_q[$];
        bit        plane_2d;
        int        n_err;
        int        n_checked;
        int        n_on;
        int        n_off;
        int        n_degen;

        function automatic logic [127:0] isqrt_nearest(logic [127:0] s);
            logic [127:0] r;
            logic [127:0] c;
            r = 0;
            for (int b = 62; b >= 0; b--) begin
                c = r | (128'd1 << b);
                if (c * c <= s) r = c;
            end
            if (s - r * r > r) r = r + 1;
            return r;
        endfunction

        function automatic psd_pkg::t_out_word predict(psd_pkg::t_in_word w);
            psd_pkg::t_out_word  o;
            logic signed [127:0] p[3], s[3], d[3], v, dot, len2, e, acc;
            logic signed [127:0] m;
            logic        [127:0] u, rem, t, root_v;
            int                  dims;
            o = '0;
            o.status = psd_pkg::ST_ON;
            dims = plane_2d ? 2 : 3;
            p[0] = w.point_x; p[1] = w.point_y; p[2] = w.point_z;
            s[0] = w.start_x; s[1] = w.start_y; s[2] = w.start_z;
            d[0] = 128'(signed'(w.end_x)) - s[0];
            d[1] = 128'(signed'(w.end_y)) - s[1];
            d[2] = 128'(signed'(w.end_z)) - s[2];
            dot = 0;
            len2 = 0;
            for (int i = 0; i < dims; i++) begin
                v = p[i] - s[i];
                dot += v * d[i];
                len2 += d[i] * d[i];
            end
            if (len2 == 0) begin
                o.status = psd_pkg::ST_DEGEN;
                return o;
            end
            if (dot < 0 || dot > len2) begin
                o.status = psd_pkg::ST_OFF;
                return o;
            end
            // u truncated to U_FRAC fraction bits; exactly one when dot equals len2
            if (dot == len2) u = 128'd1 << U_FRAC;
            else begin
                u = 0;
                rem = dot;
                for (int k = 0; k < U_FRAC; k++) begin
                    rem = rem << 1;
                    u = u << 1;
                    if (rem >= len2) begin
                        rem = rem - len2;
                        u[0] = 1'b1;
                    end
                end
            end
            acc = 0;
            for (int i = 0; i < 3; i++) begin
                if (i < dims) begin
                    t = (d[i] < 0 ? -d[i] : d[i]) * u + (128'd1 << (U_FRAC - 1));
                    m = signed'(t >> U_FRAC);
                    m = d[i] < 0 ? s[i] - m : s[i] + m;
                    e = p[i] - m;
                    acc += e * e;
                    if (i == 0) o.foot_x = m[CB-1:0];
                    if (i == 1) o.foot_y = m[CB-1:0];
                    if (i == 2) o.foot_z = m[CB-1:0];
                end
            end
            root_v = isqrt_nearest(acc);
            if (root_v > {CB+1{1'b1}}) root_v = {CB+1{1'b1}};
            o.distance = root_v[CB:0];
            return o;
        endfunction

        function void note_input(psd_pkg::t_in_word w);
            expected_q.push_back(predict(w));
        endfunction

        function void check_result(psd_pkg::t_out_word got);
            psd_pkg::t_out_word want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result word %h", $realtime, got);
                n_err++;
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            case (want.status)
                psd_pkg::ST_ON:  n_on++;
                psd_pkg::ST_OFF: n_off++;
                default:         n_degen++;
            endcase
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $realtime, want.status,
                         got.status);
                n_err++;
            end
            if (got.distance !== want.distance) begin
                $display("%0t: distance expected %h actual %h", $realtime, want.distance,
                         got.distance);
                n_err++;
            end
            if (got.foot_x !== want.foot_x) begin
                $display("%0t: foot_x expected %h actual %h", $realtime, want.foot_x,
                         got.foot_x);
                n_err++;
            end
            if (got.foot_y !== want.foot_y) begin
                $display("%0t: foot_y expected %h actual %h", $realtime, want.foot_y,
                         got.foot_y);
                n_err++;
            end
            if (got.foot_z !== want.foot_z) begin
                $display("%0t: foot_z expected %h actual %h", $realtime, want.foot_z,
                         got.foot_z);
                n_err++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_wdata = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    psd_pkg::t_in_word  i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    psd_pkg::t_out_word o_out_data;

    foot_scoreboard sb;
    int  src_idle_pct = 0;     // chance in 100 of a gap before each word
    int  sink_stall_pct = 0;   // chance in 100 of holding off a cycle
    bit  hold_sink = 1'b0;     // long hold-off in progress
    int  idle_cycles = 0;
    int  n_sent = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    point_segment_distance i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // result side: sample on the edge, choose the next ready value after it
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
        if (!i_rst_n || hold_sink) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // watchdog: counts cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog expired with %0d words outstanding", sb.expected_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    // offer one word and hold it until it is taken; valid only drops in a gap
    task automatic send_word(psd_pkg::t_in_word w);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(w);
        n_sent++;
    endtask

    // pipeline drained, then a safe margin before touching the mode bit
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_mode(bit m);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.plane_2d = m;
    endtask

    function automatic logic [31:0] rand_coord(int shape);
        case (shape)
            0: return $urandom();
            1: return 32'(signed'($urandom_range(2000)) - 1000);
            2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'(signed'($urandom_range(1 << 20)) - (1 << 19)) << 8;
        endcase
    endfunction

    // many points near the midpoint of the segment so the on-segment path is well used
    function automatic psd_pkg::t_in_word rand_word();
        psd_pkg::t_in_word  w;
        int                 shape;
        logic signed [33:0] a;
        shape = $urandom_range(3);
        w.start_x = rand_coord(shape);
        w.start_y = rand_coord(shape);
        w.start_z = rand_coord(shape);
        w.end_x = rand_coord(shape);
        w.end_y = rand_coord(shape);
        w.end_z = rand_coord(shape);
        w.point_x = rand_coord(shape);
        w.point_y = rand_coord(shape);
        w.point_z = rand_coord(shape);
        case ($urandom_range(9))
            0: {w.end_x, w.end_y, w.end_z} = {w.start_x, w.start_y, w.start_z};
            1: {w.point_x, w.point_y, w.point_z} = {w.end_x, w.end_y, w.end_z};
            2, 3, 4, 5: begin
                // point near the midpoint
                a = (34'(signed'(w.start_x)) + w.end_x) >>> 1;
                w.point_x = a[31:0] + 32'($urandom_range(255));
                a = (34'(signed'(w.start_y)) + w.end_y) >>> 1;
                w.point_y = a[31:0] - 32'($urandom_range(255));
                a = (34'(signed'(w.start_z)) + w.end_z) >>> 1;
                w.point_z = a[31:0] ^ 32'($urandom_range(255));
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic psd_pkg::t_in_word mk(logic [31:0] px, py, pz, sx, sy, sz,
                                             ex, ey, ez);
        psd_pkg::t_in_word w;
        w = {px, py, pz, sx, sy, sz, ex, ey, ez};
        return w;
    endfunction

    task automatic directed_set();
        localparam logic [31:0] MX = 32'h7fff_ffff;
        localparam logic [31:0] MN = 32'h8000_0000;
        localparam logic [31:0] ONE = 32'h0001_0000;
        // degenerate segment
        send_word(mk(ONE, ONE, ONE, 0, 0, 0, 0, 0, 0));
        // degenerate only in x/y: differs in 3d and 2d mode
        send_word(mk(ONE, 0, 0, 0, 0, 0, 0, 0, ONE));
        // foot at start, at end, in the middle
        send_word(mk(0, ONE, 0, 0, 0, 0, ONE, 0, 0));
        send_word(mk(ONE, ONE, ONE, 0, 0, 0, ONE, 0, 0));
        send_word(mk(ONE >> 1, ONE, ONE, 0, 0, 0, ONE, 0, 0));
        // off segment on both sides
        send_word(mk(-ONE, 0, 0, 0, 0, 0, ONE, 0, 0));
        send_word(mk(2 * ONE, 0, 0, 0, 0, 0, ONE, 0, 0));
        // extreme coordinates
        send_word(mk(MX, MX, MX, MN, MN, MN, MX, MX, MX));
        send_word(mk(MN, MN, MN, MN, MN, MN, MX, MX, MX));
        send_word(mk(MN, MX, MN, MX, MN, MX, MN, MX, MN));
        send_word(mk(0, 0, 0, MN, MN, MN, MX, MX, MX));
        send_word(mk(MX, MN, 0, MN, MN, 0, MX, MX, 0));
        send_word(mk(MN, MX, MX, MX, MX, MX, MN, MN, MN));
        send_word(mk(32'hffff_ffff, 1, MX, 1, 32'hffff_ffff, MN, 3, 7, 5));
        // odd ratio
        send_word(mk(ONE, 2 * ONE, 5, 0, 0, 0, 3 * ONE, 7 * ONE, 11));
    endtask

    task automatic random_phase(int n, int idle, int stall);
        src_idle_pct = idle;
        sink_stall_pct = stall;
        repeat (n) send_word(rand_word());
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default mode after reset is 3d
        directed_set();
        random_phase(150, 0, 0);
        drain();

        write_mode(1'b1);
        directed_set();
        random_phase(150, 64, 0);
        drain();

        write_mode(1'b0);
        random_phase(150, 0, 64);
        // long hold-off on the result side while words keep coming
        fork
            begin
                hold_sink = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            random_phase(150, 0, 0);
        join
        drain();

        write_mode(1'b1);
        random_phase(200, 11, 11);
        drain();

        write_mode(1'b0);
        random_phase(220, 11, 11);
        drain();

        $display("sent %0d words, checked %0d: %0d on segment, %0d off, %0d degenerate",
                 n_sent, sb.n_checked, sb.n_on, sb.n_off, sb.n_degen);
        if (sb.n_err == 0 && sb.expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches, %0d words missing", sb.n_err, sb.expected_q.size());
            $display("tb: failure");
        end
        $finish;
    end
endmodule
